### design/modular_exponentiation_assert.svh
// Assertion macros for the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Implication checked outside reset.
`define MEXP_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("modular exponentiation: implication failed");

// Condition on the cycle after a given one, checked during reset as well.
`define MEXP_ASSERT_NEXT(name, clk_s, ante, cons) \
  name: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("modular exponentiation: next-cycle check failed");

`endif

### design/mexp_pkg.sv
// Shared types, constants and reduction functions for modular exponentiation.
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int DATA_W       = 8;
  localparam int MOD_W        = 9;
  localparam int PROD_W       = 2 * MOD_W;
  localparam int EXP_BITS_DEF = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(17);

  // One queued transaction, already classified by the front end.
  typedef struct packed {
    logic [MOD_W-1:0]  base_r;
    logic [DATA_W-1:0] exponent;
    logic              zero_mod;
  } qentry_t;

  // Data handed from one exponent-bit stage to the next.
  typedef struct packed {
    logic              valid;
    logic [MOD_W-1:0]  acc;
    logic [MOD_W-1:0]  sq;
    logic [DATA_W-1:0] exponent;
    logic              zero_mod;
  } stage_t;

  // Products inside a stage, before and after partial reduction.
  typedef struct packed {
    logic              valid;
    logic              mul_en;
    logic [PROD_W-1:0] pa;
    logic [PROD_W-1:0] ps;
    logic [DATA_W-1:0] exponent;
    logic              zero_mod;
  } prod_t;

  // Base below 256, so the quotient has at most eight bits.
  function automatic logic [MOD_W-1:0] base_mod(logic [DATA_W-1:0] b, logic [MOD_W-1:0] m);
    logic [DATA_W+MOD_W-1:0] r;
    logic [DATA_W+MOD_W-1:0] t;
    r = (DATA_W+MOD_W)'(b);
    for (int k = DATA_W - 1; k >= 0; k--) begin
      t = (DATA_W+MOD_W)'(m) << k;
      if (r >= t) begin
        r = r - t;
      end
    end
    return r[MOD_W-1:0];
  endfunction

  // Products of two residues are below m squared, so the quotient fits in
  // nine bits; the upper five quotient bits are resolved here.
  function automatic logic [PROD_W-1:0] red_hi(logic [PROD_W-1:0] p, logic [MOD_W-1:0] m);
    logic [PROD_W-1:0] r;
    logic [PROD_W-1:0] t;
    r = p;
    for (int k = MOD_W - 1; k >= 4; k--) begin
      t = PROD_W'(m) << k;
      if (r >= t) begin
        r = r - t;
      end
    end
    return r;
  endfunction

  // Lower four quotient bits.
  function automatic logic [PROD_W-1:0] red_lo(logic [PROD_W-1:0] p, logic [MOD_W-1:0] m);
    logic [PROD_W-1:0] r;
    logic [PROD_W-1:0] t;
    r = p;
    for (int k = 3; k >= 0; k--) begin
      t = PROD_W'(m) << k;
      if (r >= t) begin
        r = r - t;
      end
    end
    return r;
  endfunction

endpackage

### design/mexp_queue.sv
// Short queue between the front end and the exponentiation pipeline.
`timescale 1ns / 1ps

module mexp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mexp_pkg::qentry_t wr_entry,
  input  logic             pop,
  output mexp_pkg::qentry_t head,
  output logic             empty,
  output logic             full
);
  import mexp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  qentry_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/mexp_front.sv
// Front end: modulus register, transaction acceptance and classification.
`timescale 1ns / 1ps

module mexp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mexp_pkg::DATA_W-1:0] base_value,
  input  logic [mexp_pkg::DATA_W-1:0] exponent,
  input  logic                        cfg_valid,
  input  logic [mexp_pkg::MOD_W-1:0]  cfg_data,
  input  logic                        q_full,
  output logic                        busy,
  output logic                        cfg_ready,
  output logic                        push,
  output mexp_pkg::qentry_t           wr_entry,
  output logic [mexp_pkg::MOD_W-1:0]  modulus
);
  import mexp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = rst || q_full;
  assign push      = start && !busy;

  // The base is reduced once here so every stage works on residues.
  always_comb begin
    wr_entry.base_r   = base_mod(base_value, modulus);
    wr_entry.exponent = exponent;
    wr_entry.zero_mod = (modulus == '0);
  end

endmodule

### design/mexp_cell.sv
// One exponent bit of square-and-multiply: multiply, then two reduction steps.
`timescale 1ns / 1ps

module mexp_cell #(
  parameter int BIT = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mexp_pkg::MOD_W-1:0] modulus,
  input  mexp_pkg::stage_t           din,
  output mexp_pkg::stage_t           dout
);
  import mexp_pkg::*;

  localparam int IDX_W = $clog2(DATA_W);
  localparam logic [IDX_W-1:0] BIT_IDX = IDX_W'(BIT);

  prod_t             s1;
  prod_t             s1_next;
  prod_t             s2;
  prod_t             s2_next;
  stage_t            dout_next;
  logic [PROD_W-1:0] acc_red;
  logic [PROD_W-1:0] sq_red;

  always_comb begin
    s1_next.valid    = din.valid;
    s1_next.exponent = din.exponent;
    s1_next.zero_mod = din.zero_mod;
    s1_next.mul_en   = din.exponent[BIT_IDX];
    s1_next.pa       = din.exponent[BIT_IDX] ? PROD_W'(din.acc) * PROD_W'(din.sq)
                                             : PROD_W'(din.acc);
    s1_next.ps       = PROD_W'(din.sq) * PROD_W'(din.sq);
  end

  // When the bit is clear the accumulator passes through unreduced.
  always_comb begin
    s2_next    = s1;
    s2_next.pa = s1.mul_en ? red_hi(s1.pa, modulus) : s1.pa;
    s2_next.ps = red_hi(s1.ps, modulus);
  end

  always_comb begin
    acc_red            = s2.mul_en ? red_lo(s2.pa, modulus) : s2.pa;
    sq_red             = red_lo(s2.ps, modulus);
    dout_next.valid    = s2.valid;
    dout_next.exponent = s2.exponent;
    dout_next.zero_mod = s2.zero_mod;
    dout_next.acc      = acc_red[MOD_W-1:0];
    dout_next.sq       = sq_red[MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= '0;
      s2   <= '0;
      dout <= '0;
    end else begin
      s1   <= s1_next;
      s2   <= s2_next;
      dout <= dout_next;
    end
  end

endmodule

### design/mexp_back.sv
// Back end: drains the queue into a chain of exponent-bit stages.
`timescale 1ns / 1ps

module mexp_back #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mexp_pkg::MOD_W-1:0]  modulus,
  input  mexp_pkg::qentry_t           head,
  input  logic                        q_empty,
  output logic                        pop,
  output logic [mexp_pkg::DATA_W-1:0] power_result,
  output logic                        done
);
  import mexp_pkg::*;

  // Exponent bits above the port width are always zero and change nothing.
  localparam int NUM_CELLS = (EXP_BITS < DATA_W) ? EXP_BITS : DATA_W;

  stage_t chain [NUM_CELLS+1];

  // The pipeline never stalls, so the head is taken whenever there is one.
  assign pop = !q_empty;

  always_comb begin
    chain[0].valid    = pop;
    chain[0].acc      = MOD_W'(1);
    chain[0].sq       = head.base_r;
    chain[0].exponent = head.exponent;
    chain[0].zero_mod = head.zero_mod;
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_bit
    mexp_cell #(
      .BIT(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .modulus(modulus),
      .din    (chain[i]),
      .dout   (chain[i+1])
    );
  end

  assign done         = chain[NUM_CELLS].valid;
  assign power_result = chain[NUM_CELLS].zero_mod ? '0 : chain[NUM_CELLS].acc[DATA_W-1:0];

endmodule

### design/modular_exponentiation.sv
// Top level of the modular exponentiation block.
`timescale 1ns / 1ps

// Computes base_value to the power exponent modulo the configured modulus, by
// right-to-left square-and-multiply. One transaction is accepted per clock:
// start is taken whenever busy is low, and busy is high only during reset or
// when the two-entry queue is full, which does not happen since the pipeline
// behind it moves every cycle. Each exponent bit has its own pipeline cell
// (multiply, then two halves of the modular reduction, each registered), so
// done is raised once a transaction has passed through the cells of all
// min(EXP_BITS, 8) exponent bits, with power_result beside it; there is no
// way to hold it, so the receiver must take it then. An exponent of zero gives
// 1, and a modulus of zero gives 0. The modulus is written through cfg_valid
// and cfg_data and must only change while idle.
module modular_exponentiation #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [mexp_pkg::DATA_W-1:0] base_value,
  input  logic [mexp_pkg::DATA_W-1:0] exponent,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mexp_pkg::MOD_W-1:0]  cfg_data,
  output logic [mexp_pkg::DATA_W-1:0] power_result,
  output logic                        done
);
  import mexp_pkg::*;

  qentry_t          wr_entry;
  qentry_t          head;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;
  logic [MOD_W-1:0] modulus;

  mexp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .base_value(base_value),
    .exponent  (exponent),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .push      (push),
    .wr_entry  (wr_entry),
    .modulus   (modulus)
  );

  mexp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_entry(wr_entry),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  mexp_back #(
    .EXP_BITS(EXP_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .modulus     (modulus),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .power_result(power_result),
    .done        (done)
  );

endmodule

### design/mexp_checker.sv
// Port-level checker for modular exponentiation, bound to the top level.
`timescale 1ns / 1ps

`include "modular_exponentiation_assert.svh"

module mexp_checker #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [mexp_pkg::DATA_W-1:0] exponent,
  input logic [mexp_pkg::DATA_W-1:0] power_result,
  input logic                        done
);
  import mexp_pkg::*;

  localparam int NUM_CELLS = (EXP_BITS < DATA_W) ? EXP_BITS : DATA_W;
  localparam int LAT       = 3 * NUM_CELLS + 1;

  logic accepted;

  assign accepted = start && !busy;

  // Every transaction gives exactly one result after the fixed latency.
  `MEXP_ASSERT_IMPLY(a_result_follows, clk, rst, accepted, ##LAT done)
  `MEXP_ASSERT_IMPLY(a_result_has_source, clk, rst, done, $past(accepted, LAT))
  // A zero exponent must give 1 or 0; the check accepts either value.
  `MEXP_ASSERT_IMPLY(a_zero_exp, clk, rst, accepted && exponent == '0, ##LAT (power_result == DATA_W'(1) || power_result == '0))
  `MEXP_ASSERT_NEXT(a_reset_flush, clk, rst, !done)

endmodule

bind modular_exponentiation mexp_checker #(
  .EXP_BITS(EXP_BITS)
) u_mexp_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .exponent    (exponent),
  .power_result(power_result),
  .done        (done)
);
